>>> rtl/mtfs_pkg.sv
`default_nettype none

package mtfs_pkg;

   localparam int LIST_DEPTH = 64;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = IDX_W + 1;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 6;
   localparam int STATUS_W   = 2;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic compare;
      logic in_list;
      logic append;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/mtfs_req_if.sv
`default_nettype none

interface mtfs_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    operation;
   logic signed [mtfs_pkg::VALUE_W-1:0]     value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/mtfs_rsp_if.sv
`default_nettype none

interface mtfs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mtfs_pkg::STATUS_W-1:0]      status;
   logic [mtfs_pkg::POS_W-1:0]         position;

   modport source (output valid, output status, output position, input ready);
   modport sink   (input valid, input status, input position, output ready);
endinterface

`default_nettype wire

>>> rtl/mtfs_cell.sv
`default_nettype none

module mtfs_cell (
   input  wire                               clock,
   input  wire                               reset,
   input  mtfs_pkg::cell_ctrl_type           ctrl,
   input  wire  [mtfs_pkg::VALUE_W-1:0]      key,
   input  wire  [mtfs_pkg::VALUE_W-1:0]      neighbor,
   output logic [mtfs_pkg::VALUE_W-1:0]      entry_ff,
   output logic                              match_ff
);

   logic [mtfs_pkg::VALUE_W-1:0] entry_in;
   logic                         match_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.append) begin
         entry_in = key;
      end else if (ctrl.shift) begin
         entry_in = neighbor;
      end
   end

   always_comb begin
      match_in = match_ff;
      if (ctrl.compare) begin
         match_in = ctrl.in_list && (entry_ff == key);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/move_to_front_search_top.sv
// move-to-front search list
// req channel: operation 0 appends value at the tail, operation 1 searches
// for value, reports its position from the front and moves it to the front
// rsp channel: one response per request, status and position
// the list is a row of cells, one entry each; every cell compares its entry
// with the key in parallel and takes its front neighbor's entry on a shift
// a request is compared when it is accepted, then resolved and shifted in
// the resolve state; req ready is low while a request is being resolved, so
// a new request is not accepted until the last one has been resolved
// the response sits in an output register; a new request is accepted while
// it waits, but resolving stalls until the receiver takes the old response
// reset clears the entry count and the handshake state; entry contents are
// not cleared, only entries below the count can ever match
`default_nettype none

module move_to_front_search_top (
   input  wire           clock,
   input  wire           reset,
   mtfs_req_if.sink      req_ch,
   mtfs_rsp_if.source    rsp_ch
);

   localparam int DEPTH = mtfs_pkg::LIST_DEPTH;
   localparam int IDX_W = mtfs_pkg::IDX_W;
   localparam int CNT_W = mtfs_pkg::CNT_W;
   localparam int VW    = mtfs_pkg::VALUE_W;
   localparam int POS_W = mtfs_pkg::POS_W;

   localparam logic ST_IDLE    = 1'b0;
   localparam logic ST_RESOLVE = 1'b1;

   logic                          state_ff, state_in;
   logic                          op_ff, op_in;
   logic [VW-1:0]                 key_ff, key_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mtfs_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [POS_W-1:0]              position_ff, position_in;

   logic                          req_fire;
   logic                          resolve;
   logic [VW-1:0]                 cmp_key;
   logic [VW-1:0]                 cell_entry [DEPTH];
   logic [DEPTH-1:0]              match;
   logic [DEPTH:0]                ahead;
   logic [DEPTH-1:0]              first;
   logic [IDX_W-1:0]              hit_idx;
   logic [IDX_W+POS_W-1:0]        pos_wide;
   logic                          any_hit;
   logic                          full;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign resolve      = (state_ff == ST_RESOLVE) && (!rsp_valid_ff || rsp_ch.ready);
   assign cmp_key      = req_ch.value;
   assign full         = (count_ff == CNT_W'(DEPTH));

   // prefix of matches in front of each cell
   always_comb begin
      ahead[0] = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         ahead[i+1] = ahead[i] | match[i];
      end
   end

   assign first   = match & ~ahead[DEPTH-1:0];
   assign any_hit = ahead[DEPTH];

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   assign pos_wide = {{POS_W{1'b0}}, hit_idx};

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(g);
      mtfs_pkg::cell_ctrl_type ctrl;
      logic [VW-1:0]           key_sel;
      logic [VW-1:0]           neighbor;

      assign ctrl.compare = req_fire;
      assign ctrl.in_list = (CELL_IDX < count_ff);
      assign ctrl.append  = resolve && (op_ff == mtfs_pkg::OP_APPEND) && !full
                            && (count_ff == CELL_IDX);
      assign ctrl.shift   = resolve && (op_ff == mtfs_pkg::OP_SEARCH) && any_hit
                            && !ahead[g];
      assign key_sel      = req_fire ? cmp_key : key_ff;

      if (g == 0) begin : g_front
         assign neighbor = key_ff;
      end else begin : g_rest
         assign neighbor = cell_entry[g-1];
      end

      mtfs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .key      (key_sel),
         .neighbor (neighbor),
         .entry_ff (cell_entry[g]),
         .match_ff (match[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      position_in  = position_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_ch.operation;
               key_in   = req_ch.value;
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (resolve) begin
               rsp_valid_in = 1'b1;
               position_in  = '0;
               state_in     = ST_IDLE;
               if (op_ff == mtfs_pkg::OP_APPEND) begin
                  if (full) begin
                     status_in = mtfs_pkg::ST_FULL;
                  end else begin
                     status_in = mtfs_pkg::ST_APPENDED;
                     count_in  = count_ff + CNT_W'(1);
                  end
               end else if (any_hit) begin
                  status_in   = mtfs_pkg::ST_FOUND;
                  position_in = pos_wide[POS_W-1:0];
               end else begin
                  status_in = mtfs_pkg::ST_MISSING;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      status_ff   <= status_in;
      position_ff <= position_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = status_ff;
   assign rsp_ch.position = position_ff;

endmodule

`default_nettype wire
